// File: rtl/core/acsp_pkg.sv
// Package: constants, codes and the result type of the CSI sequence parser.
package acsp_pkg;

	// Default configuration
	localparam int MAX_PARAMS_DEF = 8;
	localparam int PARAM_BITS_DEF = 16;

	// Fixed result layout
	localparam int OUT_PARAMS = 8;
	localparam int OUT_BITS   = 16;
	localparam int CODE_W     = 4;
	localparam int BYTE_W     = 8;
	localparam int TOTAL_W    = 4;

	// Characters
	localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
	localparam logic [BYTE_W-1:0] CH_LBRK  = 8'h5B;
	localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
	localparam logic [BYTE_W-1:0] CH_COLOR = 8'h6D;
	localparam logic [BYTE_W-1:0] CH_UP    = 8'h41;
	localparam logic [BYTE_W-1:0] CH_DOWN  = 8'h42;
	localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h43;
	localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h44;
	localparam logic [BYTE_W-1:0] CH_POS   = 8'h48;
	localparam logic [BYTE_W-1:0] CH_CLR_S = 8'h4A;
	localparam logic [BYTE_W-1:0] CH_CLR_L = 8'h4B;

	// First parameter value that turns J into clear screen
	localparam int CLR_SCREEN_ARG = 2;

	// Result codes
	localparam logic [CODE_W-1:0] RC_PLAIN    = 4'd0;
	localparam logic [CODE_W-1:0] RC_CONSUMED = 4'd1;
	localparam logic [CODE_W-1:0] RC_COLOR    = 4'd2;
	localparam logic [CODE_W-1:0] RC_UP       = 4'd3;
	localparam logic [CODE_W-1:0] RC_DOWN     = 4'd4;
	localparam logic [CODE_W-1:0] RC_RIGHT    = 4'd5;
	localparam logic [CODE_W-1:0] RC_LEFT     = 4'd6;
	localparam logic [CODE_W-1:0] RC_POS      = 4'd7;
	localparam logic [CODE_W-1:0] RC_CLR_SCR  = 4'd8;
	localparam logic [CODE_W-1:0] RC_CLR_LINE = 4'd9;

	// Parser phases
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_ESC  = 2'd1;
	localparam logic [1:0] PH_SEQ  = 2'd2;

	// One result word
	typedef struct packed {
		logic [CODE_W-1:0]                   code;
		logic [BYTE_W-1:0]                   text;
		logic [TOTAL_W-1:0]                  total;
		logic [OUT_PARAMS-1:0][OUT_BITS-1:0] params;
	} result_t;

endpackage

// File: rtl/core/acsp_byte_if.sv
// Interface: input byte channel.
interface acsp_byte_if
	import acsp_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink   (input valid, input byte_in, output ready);
endinterface

// File: rtl/core/acsp_result_if.sv
// Interface: parser result channel.
interface acsp_result_if
	import acsp_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [CODE_W-1:0]  result_code;
	logic [BYTE_W-1:0]  text_byte;
	logic [TOTAL_W-1:0] param_total;
	logic [OUT_BITS-1:0] param_zero;
	logic [OUT_BITS-1:0] param_one;
	logic [OUT_BITS-1:0] param_two;
	logic [OUT_BITS-1:0] param_three;
	logic [OUT_BITS-1:0] param_four;
	logic [OUT_BITS-1:0] param_five;
	logic [OUT_BITS-1:0] param_six;
	logic [OUT_BITS-1:0] param_seven;

	modport source (
		output valid, output result_code, output text_byte, output param_total,
		output param_zero, output param_one, output param_two, output param_three,
		output param_four, output param_five, output param_six, output param_seven,
		input ready
	);
	modport sink (
		input valid, input result_code, input text_byte, input param_total,
		input param_zero, input param_one, input param_two, input param_three,
		input param_four, input param_five, input param_six, input param_seven,
		output ready
	);
endinterface

// File: rtl/core/acsp_core.sv
// Parser state (phase, parameter store, index) and the per-byte step logic.
module acsp_core
	import acsp_pkg::*;
#(
	parameter int MAX_PARAMS = MAX_PARAMS_DEF,
	parameter int PARAM_BITS = PARAM_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  logic [BYTE_W-1:0] byte_in,
	output result_t           res
);

	localparam int IDX_W = $clog2(MAX_PARAMS + 1);
	localparam int MUL_W = PARAM_BITS + 4;
	localparam int EXT_W = (PARAM_BITS > OUT_BITS) ? PARAM_BITS : OUT_BITS;
	localparam int CAP   = (MAX_PARAMS < OUT_PARAMS) ? MAX_PARAMS : OUT_PARAMS;

	logic [1:0]            phase_q, phase_n;
	logic [IDX_W-1:0]      index_q, index_n;
	logic [PARAM_BITS-1:0] store_q [MAX_PARAMS];
	logic [PARAM_BITS-1:0] store_n [MAX_PARAMS];

	logic                  is_digit;
	logic                  idx_full;
	logic [PARAM_BITS-1:0] cur;
	logic [MUL_W-1:0]      acc;
	logic [PARAM_BITS-1:0] acc_sat;
	logic [CODE_W-1:0]     final_code;
	logic [CODE_W-1:0]     code_n;
	logic [BYTE_W-1:0]     text_n;
	logic [IDX_W:0]        total_w;

	assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
	assign idx_full = (index_q == IDX_W'(MAX_PARAMS));

	// Current parameter, times ten plus the digit, saturated
	always_comb begin
		cur = '0;
		for (int i = 0; i < MAX_PARAMS; i++) begin
			if (index_q == IDX_W'(i))
				cur = store_q[i];
		end
	end

	assign acc = (MUL_W'(cur) << 3) + (MUL_W'(cur) << 1)
		+ MUL_W'(byte_in - CH_ZERO);
	assign acc_sat = (acc[MUL_W-1:PARAM_BITS] != '0) ? '1 : acc[PARAM_BITS-1:0];

	// Final byte decode
	always_comb begin
		unique case (byte_in)
			CH_COLOR: final_code = RC_COLOR;
			CH_UP:    final_code = RC_UP;
			CH_DOWN:  final_code = RC_DOWN;
			CH_RIGHT: final_code = RC_RIGHT;
			CH_LEFT:  final_code = RC_LEFT;
			CH_POS:   final_code = RC_POS;
			CH_CLR_S: final_code = (store_q[0] == PARAM_BITS'(CLR_SCREEN_ARG)) ?
				RC_CLR_SCR : RC_CONSUMED;
			CH_CLR_L: final_code = RC_CLR_LINE;
			default:  final_code = RC_CONSUMED;
		endcase
	end

	// Next state and result code
	always_comb begin
		phase_n = phase_q;
		index_n = index_q;
		store_n = store_q;
		code_n  = RC_CONSUMED;
		text_n  = '0;
		unique case (phase_q)
			PH_ESC: begin
				for (int i = 0; i < MAX_PARAMS; i++)
					store_n[i] = '0;
				index_n = '0;
				if (byte_in == CH_LBRK) begin
					phase_n = PH_SEQ;
				end else begin
					phase_n = PH_IDLE;
					code_n  = RC_PLAIN;
					text_n  = byte_in;
				end
			end
			PH_SEQ: begin
				if (is_digit) begin
					for (int i = 0; i < MAX_PARAMS; i++) begin
						if (!idx_full && index_q == IDX_W'(i))
							store_n[i] = acc_sat;
					end
				end else if (byte_in == CH_SEMI) begin
					if (!idx_full)
						index_n = index_q + 1'b1;
				end else begin
					code_n  = final_code;
					phase_n = PH_IDLE;
				end
			end
			default: begin
				if (byte_in == CH_ESC) begin
					phase_n = PH_ESC;
				end else begin
					phase_n = PH_IDLE;
					code_n  = RC_PLAIN;
					text_n  = byte_in;
				end
			end
		endcase
	end

	assign res.code = code_n;
	assign res.text = text_n;

	// Parameter count: index plus one, capped
	assign total_w   = (IDX_W + 1)'(index_n) + 1'b1;
	assign res.total = (total_w > (IDX_W + 1)'(CAP)) ? TOTAL_W'(CAP) : TOTAL_W'(total_w);

	// Parameter outputs, saturated to the output width
	for (genvar g = 0; g < OUT_PARAMS; g++) begin : g_out
		if (g < MAX_PARAMS) begin : g_used
			logic [EXT_W-1:0] ext;
			assign ext = EXT_W'(store_n[g]);
			assign res.params[g] = ((ext >> OUT_BITS) != '0) ? '1 : ext[OUT_BITS-1:0];
		end else begin : g_unused
			assign res.params[g] = '0;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			index_q <= '0;
			for (int i = 0; i < MAX_PARAMS; i++)
				store_q[i] <= '0;
		end else if (step_en) begin
			phase_q <= phase_n;
			index_q <= index_n;
			store_q <= store_n;
		end
	end

	// The index never passes the store depth
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		index_q <= IDX_W'(MAX_PARAMS))
		else $error("parameter index beyond store depth");

endmodule

// File: rtl/core/ansi_csi_sequence_parser_top.sv
// Top level: input byte register, parser core and result register.
//
//  channel    | dir | word
//  -----------+-----+------------------------------------------------------
//  byte_ch    | in  | byte_in (8)
//  result_ch  | out | result_code, text_byte, param_total, param_zero..seven
//
// One byte per cycle sustained while result_ch.ready stays high; an accepted
// byte waits in the input register, is stepped through the core and is
// presented from the result register. The step is a times-ten shift-add with
// saturation. arst_n clears phase, index, parameters and both valid flags.
// A stalled result holds in the result register while one more byte waits in
// the input register; byte_ch.ready drops only when both are full.
module ansi_csi_sequence_parser_top
	import acsp_pkg::*;
#(
	parameter int MAX_PARAMS = MAX_PARAMS_DEF,
	parameter int PARAM_BITS = PARAM_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	acsp_byte_if.sink    byte_ch,
	acsp_result_if.source result_ch
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_valid_q;
	result_t           res_q;
	result_t           res_n;
	logic              advance;

	assign advance       = valid_s1 && (!out_valid_q || result_ch.ready);
	assign byte_ch.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.ready && byte_ch.valid)
			byte_s1 <= byte_ch.byte_in;
	end

	acsp_core #(
		.MAX_PARAMS (MAX_PARAMS),
		.PARAM_BITS (PARAM_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.byte_in (byte_s1),
		.res     (res_n)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_n;
	end

	assign result_ch.valid       = out_valid_q;
	assign result_ch.result_code = res_q.code;
	assign result_ch.text_byte   = res_q.text;
	assign result_ch.param_total = res_q.total;
	assign result_ch.param_zero  = res_q.params[0];
	assign result_ch.param_one   = res_q.params[1];
	assign result_ch.param_two   = res_q.params[2];
	assign result_ch.param_three = res_q.params[3];
	assign result_ch.param_four  = res_q.params[4];
	assign result_ch.param_five  = res_q.params[5];
	assign result_ch.param_six   = res_q.params[6];
	assign result_ch.param_seven = res_q.params[7];

	// A stepped byte always lands in the result register
	a_step_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("stepped byte lost");

	// A waiting byte holds when the result side is blocked
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("pending byte dropped");

	// Echo only on plain bytes
	a_echo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.code != RC_PLAIN |-> res_q.text == '0)
		else $error("echo on non-plain result");

	// Count is never zero and codes stay in range
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> res_q.total != '0 && res_q.code <= RC_CLR_LINE)
		else $error("result fields out of range");

endmodule
